// File: design/nrm_pkg.sv
// Shared types and constants for the 3D vector normalizer.
// Used by the pipeline stage modules and the top level.
`default_nettype none

package nrm_pkg;

    localparam int LANES   = 3;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 64;
    localparam int QUO_W   = 63;
    localparam int ROOT_W  = 32;
    localparam int DIV_STEPS = QUO_W - 1;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } ctl_t;

    typedef struct packed {
        logic [SQ_W-1:0]                 den;
        logic [LANES-1:0][SQ_W-1:0]      rem;
        logic [LANES-1:0][QUO_W-1:0]     quo;
    } div_t;

    typedef struct packed {
        logic [LANES-1:0][QUO_W-1:0]     rad;
        logic [LANES-1:0][ROOT_W-1:0]    root;
    } sqrt_t;

endpackage

`default_nettype wire

// File: design/nrm_if.sv
// Valid/ready channel interfaces for the vector normalizer.
// Standalone; widths follow the fixed field widths.
`default_nettype none

interface nrm_vec_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;

    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface nrm_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               ok;

    modport source (output valid, out_x, out_y, out_z, ok, input ready);
    modport sink   (input valid, out_x, out_y, out_z, ok, output ready);
endinterface

`default_nettype wire

// File: design/nrm_front.sv
// Front stages: magnitudes and squares, sum of squares, first quotient bit.
// Depends on nrm_pkg.
`default_nettype none

module nrm_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic signed [31:0]  in_x,
    input  wire logic signed [31:0]  in_y,
    input  wire logic signed [31:0]  in_z,
    output nrm_pkg::ctl_t            ctl_reg,
    output nrm_pkg::div_t            div_reg
);

    logic [nrm_pkg::LANES-1:0][31:0]                raw;
    logic [nrm_pkg::LANES-1:0][nrm_pkg::MAG_W-1:0]  mag;
    logic [nrm_pkg::LANES-1:0]                      neg;

    logic                                           v1_reg;
    logic [nrm_pkg::LANES-1:0]                      neg1_reg;
    logic [nrm_pkg::LANES-1:0][nrm_pkg::SQ_W-1:0]   sq1_reg;

    logic                                           v2_reg;
    logic [nrm_pkg::LANES-1:0]                      neg2_reg;
    logic [nrm_pkg::LANES-1:0][nrm_pkg::SQ_W-1:0]   sq2_reg;
    logic [nrm_pkg::SQ_W-1:0]                       sum2_reg;

    nrm_pkg::ctl_t                                  ctl_next;
    nrm_pkg::div_t                                  div_next;

    assign raw[0] = in_x;
    assign raw[1] = in_y;
    assign raw[2] = in_z;

    // The most negative value maps to 2^31, which still fits unsigned.
    always_comb
    begin
        for (int i = 0; i < nrm_pkg::LANES; i++)
        begin
            neg[i] = raw[i][31];
            mag[i] = neg[i] ? (32'd0 - raw[i]) : raw[i];
        end
    end

    // Since each square is at most the sum, the first quotient bit is a compare.
    always_comb
    begin
        ctl_next.valid = v2_reg;
        ctl_next.zero  = (sum2_reg == '0);
        ctl_next.neg   = neg2_reg;
        div_next.den   = sum2_reg;
        for (int i = 0; i < nrm_pkg::LANES; i++)
        begin
            div_next.quo[i] = '0;
            if (sq2_reg[i] >= sum2_reg)
            begin
                div_next.rem[i]    = sq2_reg[i] - sum2_reg;
                div_next.quo[i][0] = 1'b1;
            end
            else
            begin
                div_next.rem[i] = sq2_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= neg;
            for (int i = 0; i < nrm_pkg::LANES; i++)
            begin
                sq1_reg[i] <= {32'd0, mag[i]} * {32'd0, mag[i]};
            end
            neg2_reg <= neg1_reg;
            sq2_reg  <= sq1_reg;
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            div_reg  <= div_next;
        end
    end

endmodule

`default_nettype wire

// File: design/nrm_div_step.sv
// One restoring division step for all three lanes: one quotient bit per stage.
// Depends on nrm_pkg.
`default_nettype none

module nrm_div_step (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire nrm_pkg::ctl_t  ctl_in,
    input  wire nrm_pkg::div_t  div_in,
    output nrm_pkg::ctl_t       ctl_reg,
    output nrm_pkg::div_t       div_reg
);

    nrm_pkg::div_t           div_next;
    logic [nrm_pkg::SQ_W:0]  shifted;
    logic [nrm_pkg::SQ_W:0]  diff;

    always_comb
    begin
        div_next.den = div_in.den;
        shifted      = '0;
        diff         = '0;
        for (int i = 0; i < nrm_pkg::LANES; i++)
        begin
            shifted = {div_in.rem[i], 1'b0};
            diff    = shifted - {1'b0, div_in.den};
            if (shifted >= {1'b0, div_in.den})
            begin
                div_next.rem[i] = diff[nrm_pkg::SQ_W-1:0];
                div_next.quo[i] = {div_in.quo[i][nrm_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                div_next.rem[i] = shifted[nrm_pkg::SQ_W-1:0];
                div_next.quo[i] = {div_in.quo[i][nrm_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

endmodule

`default_nettype wire

// File: design/nrm_sqrt_step.sv
// One bit of a digit-by-digit integer square root for all three lanes.
// Depends on nrm_pkg; BIT selects the root bit that this stage decides.
`default_nettype none

module nrm_sqrt_step #(
    parameter int BIT = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire nrm_pkg::ctl_t   ctl_in,
    input  wire nrm_pkg::sqrt_t  sq_in,
    output nrm_pkg::ctl_t        ctl_reg,
    output nrm_pkg::sqrt_t       sq_reg
);

    localparam int EXT_W = nrm_pkg::SQ_W + 1;

    nrm_pkg::sqrt_t      sq_next;
    logic [EXT_W-1:0]    trial;
    logic [EXT_W-1:0]    rad_ext;
    logic [EXT_W-1:0]    diff;

    // Setting this bit raises root^2 by 2*root*2^BIT + 2^(2*BIT).
    always_comb
    begin
        trial   = '0;
        rad_ext = '0;
        diff    = '0;
        for (int i = 0; i < nrm_pkg::LANES; i++)
        begin
            trial   = (EXT_W'(sq_in.root[i]) << (BIT + 1)) + (EXT_W'(1) << (2 * BIT));
            rad_ext = EXT_W'(sq_in.rad[i]);
            diff    = rad_ext - trial;
            if (rad_ext >= trial)
            begin
                sq_next.rad[i]  = diff[nrm_pkg::QUO_W-1:0];
                sq_next.root[i] = sq_in.root[i] | (nrm_pkg::ROOT_W'(1) << BIT);
            end
            else
            begin
                sq_next.rad[i]  = sq_in.rad[i];
                sq_next.root[i] = sq_in.root[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

endmodule

`default_nettype wire

// File: design/vector3_accurate_normalize.sv
// Top level of the 3D vector normalizer: front, divider chain, root chain, output.
// Depends on nrm_pkg, nrm_if, nrm_front, nrm_div_step and nrm_sqrt_step.
//
//   channel   dir   payload                         handshake
//   vec       in    in_x, in_y, in_z (Q15.16)       valid/ready
//   res       out   out_x, out_y, out_z (Q1.30), ok valid/ready
//
// One vector enters per cycle while the output is not stalled. The pipeline is
// made of three front stages, the 62 restoring division stages, the 32 square
// root stages and the output register.
// Reset clears only the control flags. When a result waits unaccepted the whole
// pipeline holds, and vec.ready stays low until the result is taken.
`default_nettype none

module vector3_accurate_normalize (
    input  wire logic clk,
    input  wire logic rst_n,
    nrm_vec_if.sink   vec,
    nrm_res_if.source res
);

    localparam int DIV_N  = nrm_pkg::DIV_STEPS;
    localparam int ROOT_N = nrm_pkg::ROOT_W;

    logic en;

    nrm_pkg::ctl_t  dctl [0:DIV_N];
    nrm_pkg::div_t  ddat [0:DIV_N];
    nrm_pkg::ctl_t  sctl [0:ROOT_N];
    nrm_pkg::sqrt_t sdat [0:ROOT_N];

    logic [nrm_pkg::LANES-1:0][31:0]  res_next;
    logic [nrm_pkg::ROOT_W:0]         rounded;
    logic [nrm_pkg::LANES-1:0][31:0]  val_reg;
    logic                             ok_reg;
    logic                             valid_reg;

    assign en        = !valid_reg || res.ready;
    assign vec.ready = en;

    nrm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vec.valid),
        .in_x     (vec.in_x),
        .in_y     (vec.in_y),
        .in_z     (vec.in_z),
        .ctl_reg  (dctl[0]),
        .div_reg  (ddat[0])
    );

    for (genvar g = 0; g < DIV_N; g++)
    begin : g_div
        nrm_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (dctl[g]),
            .div_in  (ddat[g]),
            .ctl_reg (dctl[g+1]),
            .div_reg (ddat[g+1])
        );
    end

    // The full quotient floor(2^62 * m^2 / s) is the radicand.
    assign sctl[0] = dctl[DIV_N];
    always_comb
    begin
        for (int i = 0; i < nrm_pkg::LANES; i++)
        begin
            sdat[0].rad[i]  = ddat[DIV_N].quo[i];
            sdat[0].root[i] = '0;
        end
    end

    for (genvar g = 0; g < ROOT_N; g++)
    begin : g_sqrt
        nrm_sqrt_step #(
            .BIT (ROOT_N - 1 - g)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (sctl[g]),
            .sq_in   (sdat[g]),
            .ctl_reg (sctl[g+1]),
            .sq_reg  (sdat[g+1])
        );
    end

    // The largest odd t not above the root gives q = (root + 1) / 2,
    // which is the quotient rounded half up.
    always_comb
    begin
        rounded = '0;
        for (int i = 0; i < nrm_pkg::LANES; i++)
        begin
            rounded = {1'b0, sdat[ROOT_N].root[i]} + 1'b1;
            if (sctl[ROOT_N].zero)
            begin
                res_next[i] = '0;
            end
            else if (sctl[ROOT_N].neg[i])
            begin
                res_next[i] = 32'd0 - rounded[nrm_pkg::ROOT_W:1];
            end
            else
            begin
                res_next[i] = rounded[nrm_pkg::ROOT_W:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= sctl[ROOT_N].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= res_next;
            ok_reg  <= !sctl[ROOT_N].zero;
        end
    end

    assign res.valid = valid_reg;
    assign res.out_x = val_reg[0];
    assign res.out_y = val_reg[1];
    assign res.out_z = val_reg[2];
    assign res.ok    = ok_reg;

endmodule

`default_nettype wire

// File: design/nrm_checker.sv
// Port-level checks for the vector normalizer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module nrm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [31:0] out_x,
    input wire logic [31:0] out_y,
    input wire logic [31:0] out_z,
    input wire logic        ok
);

    // A waiting result must hold still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(ok))
        else $error("result changed while stalled");

    // A zero vector gives zero fields.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !ok |-> out_x == 32'd0 && out_y == 32'd0 && out_z == 32'd0)
        else $error("failed result has nonzero fields");

    // Every field stays within plus or minus one in Q1.30.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ($signed(out_x) <= 32'sd1073741824 && $signed(out_x) >= -32'sd1073741824)
            && ($signed(out_y) <= 32'sd1073741824 && $signed(out_y) >= -32'sd1073741824)
            && ($signed(out_z) <= 32'sd1073741824 && $signed(out_z) >= -32'sd1073741824))
        else $error("result outside unit range");

    // The pipeline holds while a result waits, so no input is taken then.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !in_ready)
        else $error("input taken during output stall");

endmodule

bind vector3_accurate_normalize nrm_checker u_nrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (vec.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .out_x     (res.out_x),
    .out_y     (res.out_y),
    .out_z     (res.out_z),
    .ok        (res.ok)
);

`default_nettype wire
